// ===== src/fpa_pkg.sv =====
// Shared constants, function codes and pipeline types for the Q10.5 ALU.
// Used by fpa_div_pipe and fixed_point_q10_5_alu_unit; no dependencies.
package fpa_pkg;

  localparam int WORD_BITS     = 16;
  localparam int FRAC_BITS     = 5;
  localparam int HALF_SHIFT    = 2;
  localparam int QUARTER_SHIFT = 1;

  // derived shift distances, clamped at zero
  localparam int DIV2_PRE  = (FRAC_BITS > HALF_SHIFT) ? FRAC_BITS - HALF_SHIFT : 0;
  localparam int DIV3_PRE  = (FRAC_BITS > QUARTER_SHIFT) ? FRAC_BITS - QUARTER_SHIFT : 0;
  localparam int MUL4_POST = (FRAC_BITS > 2 * QUARTER_SHIFT) ?
                             FRAC_BITS - 2 * QUARTER_SHIFT : 0;
  localparam int MAX_PRE   = (DIV2_PRE > DIV3_PRE) ? DIV2_PRE : DIV3_PRE;

  localparam int SH_W      = $clog2(FRAC_BITS + 1);
  localparam int NUM_W     = WORD_BITS + MAX_PRE;
  localparam int DIV_STEPS = 4;  // quotient bits resolved per divider stage
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  // input register + divider stages + output register
  localparam int LATENCY   = DIV_STAGES + 2;

  localparam logic [3:0] FN_ITOF = 4'd0;
  localparam logic [3:0] FN_FTOI = 4'd1;
  localparam logic [3:0] FN_ADD  = 4'd2;
  localparam logic [3:0] FN_SUB  = 4'd3;
  localparam logic [3:0] FN_MUL1 = 4'd4;
  localparam logic [3:0] FN_MUL2 = 4'd5;
  localparam logic [3:0] FN_MUL3 = 4'd6;
  localparam logic [3:0] FN_MUL4 = 4'd7;
  localparam logic [3:0] FN_DIV1 = 4'd8;
  localparam logic [3:0] FN_DIV2 = 4'd9;
  localparam logic [3:0] FN_DIV3 = 4'd10;

  typedef enum logic [1:0] {
    OPC_SIMPLE,
    OPC_MUL,
    OPC_DIV
  } opc_t;

  // sideband that rides alongside the divider stages
  typedef struct packed {
    opc_t                     opc;
    logic [WORD_BITS-1:0]     simple;
    logic [2*WORD_BITS-1:0]   product;
    logic [SH_W-1:0]          post;
    logic                     neg;
    logic                     dz;
  } side_t;

endpackage

// ===== src/fixed_point_q10_5_alu_unit.sv =====
// Top level of the Q10.5 fixed-point ALU: operand decode, multiplier, result select.
// Depends on fpa_pkg and fpa_div_pipe.
//
//  channel  | ports                                      | transfer
//  ---------+--------------------------------------------+---------------------------
//  input    | start, busy, in_func, in_operand_a/_b      | edge with start && !busy
//  result   | out_strobe, out_result, out_div_by_zero    | edge ending the strobe cycle
//
// Fully pipelined: one operation per cycle, busy is never raised.
// Every operation passes the decode register, the divider stages and the output register; the divider
// resolves four quotient bits per stage over the magnitude of the sign-extended, pre-shifted dividend.
// Results come out in issue order, one strobe cycle each.
// Synchronous active-low reset clears the valid bits and the div-by-zero flag only; nothing else is held.
module fixed_point_q10_5_alu_unit import fpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           in_func,
  input  logic [WORD_BITS-1:0] in_operand_a,
  input  logic [WORD_BITS-1:0] in_operand_b,
  output logic                 out_strobe,
  output logic [WORD_BITS-1:0] out_result,
  output logic                 out_div_by_zero
);

  localparam int W = WORD_BITS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: decode ----------------
  opc_t             opc_nxt;
  logic [W-1:0]     simple_nxt;
  logic [SH_W-1:0]  sa_nxt, sb_nxt, post_nxt, pre_nxt;
  logic [W-1:0]     mx_nxt, my_nxt;
  logic [NUM_W-1:0] a_ext, num_s, num_nxt;
  logic [W-1:0]     den_nxt;

  always_comb begin
    opc_nxt    = OPC_SIMPLE;
    simple_nxt = '0;
    sa_nxt     = '0;
    sb_nxt     = '0;
    post_nxt   = '0;
    pre_nxt    = '0;
    case (in_func)
      FN_ITOF: simple_nxt = in_operand_a << FRAC_BITS;
      FN_FTOI: simple_nxt = W'($signed(in_operand_a) >>> FRAC_BITS);
      FN_ADD:  simple_nxt = in_operand_a + in_operand_b;
      FN_SUB:  simple_nxt = in_operand_a - in_operand_b;
      FN_MUL1: begin
        opc_nxt  = OPC_MUL;
        post_nxt = SH_W'(FRAC_BITS);
      end
      FN_MUL2: begin
        opc_nxt = OPC_MUL;
        sa_nxt  = SH_W'(DIV2_PRE);
        sb_nxt  = SH_W'(HALF_SHIFT);
      end
      FN_MUL3: begin
        opc_nxt = OPC_MUL;
        sa_nxt  = SH_W'(DIV3_PRE);
        sb_nxt  = SH_W'(QUARTER_SHIFT);
      end
      FN_MUL4: begin
        opc_nxt  = OPC_MUL;
        sa_nxt   = SH_W'(QUARTER_SHIFT);
        sb_nxt   = SH_W'(QUARTER_SHIFT);
        post_nxt = SH_W'(MUL4_POST);
      end
      FN_DIV1: begin
        opc_nxt  = OPC_DIV;
        post_nxt = SH_W'(FRAC_BITS);
      end
      FN_DIV2: begin
        opc_nxt  = OPC_DIV;
        pre_nxt  = SH_W'(DIV2_PRE);
        post_nxt = SH_W'(HALF_SHIFT);
      end
      FN_DIV3: begin
        opc_nxt  = OPC_DIV;
        pre_nxt  = SH_W'(DIV3_PRE);
        post_nxt = SH_W'(QUARTER_SHIFT);
      end
      default: ;  // unused codes give zero
    endcase
  end

  assign mx_nxt  = W'($signed(in_operand_a) >>> sa_nxt);
  assign my_nxt  = W'($signed(in_operand_b) >>> sb_nxt);
  assign a_ext   = NUM_W'($signed(in_operand_a));
  assign num_s   = a_ext << pre_nxt;
  assign num_nxt = num_s[NUM_W-1] ? -num_s : num_s;
  assign den_nxt = in_operand_b[W-1] ? -in_operand_b : in_operand_b;

  logic             s1_valid_r;
  opc_t             s1_opc_r;
  logic [W-1:0]     s1_simple_r;
  logic [W-1:0]     s1_mx_r, s1_my_r;
  logic [SH_W-1:0]  s1_post_r;
  logic             s1_neg_r, s1_dz_r;
  logic [NUM_W-1:0] s1_num_r;
  logic [W-1:0]     s1_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_opc_r    <= opc_nxt;
    s1_simple_r <= simple_nxt;
    s1_mx_r     <= mx_nxt;
    s1_my_r     <= my_nxt;
    s1_post_r   <= post_nxt;
    s1_neg_r    <= in_operand_a[W-1] ^ in_operand_b[W-1];
    s1_dz_r     <= (in_operand_b == '0);
    s1_num_r    <= num_nxt;
    s1_den_r    <= den_nxt;
  end

  // ---------------- multiplier, registered in the first divider stage ----------------
  logic signed [2*W-1:0] mul_prod;
  assign mul_prod = $signed(s1_mx_r) * $signed(s1_my_r);

  side_t s1_side;
  always_comb begin
    s1_side.opc     = s1_opc_r;
    s1_side.simple  = s1_simple_r;
    s1_side.product = mul_prod;
    s1_side.post    = s1_post_r;
    s1_side.neg     = s1_neg_r;
    s1_side.dz      = s1_dz_r;
  end

  logic             dv_valid;
  side_t            dv_side;
  logic [NUM_W-1:0] dv_quo;

  fpa_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_side   (s1_side),
    .in_num    (s1_num_r),
    .in_den    (s1_den_r),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  // ---------------- final stage: post shifts and select ----------------
  logic [2*W-1:0]   mul_sh;
  logic [NUM_W-1:0] quo_s, quo_sh;
  logic [W-1:0]     result_nxt;
  logic             dz_nxt;

  assign mul_sh = $signed(dv_side.product) >>> dv_side.post;
  assign quo_s  = dv_side.neg ? -dv_quo : dv_quo;
  assign quo_sh = quo_s << dv_side.post;

  always_comb begin
    result_nxt = dv_side.simple;
    dz_nxt     = 1'b0;
    case (dv_side.opc)
      OPC_MUL: result_nxt = mul_sh[W-1:0];
      OPC_DIV: begin
        dz_nxt     = dv_side.dz;
        result_nxt = dv_side.dz ? '0 : quo_sh[W-1:0];
      end
      default: result_nxt = dv_side.simple;
    endcase
  end

  logic         out_strobe_r;
  logic [W-1:0] out_result_r;
  logic         out_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      out_dz_r     <= 1'b0;
    end else begin
      out_strobe_r <= dv_valid;
      out_dz_r     <= dv_valid && dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= result_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_result      = out_result_r;
  assign out_div_by_zero = out_dz_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(LATENCY) out_strobe)
    else $error("transfer did not produce a result after LATENCY cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result strobe without a matching input transfer");

  a_dz_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_div_by_zero |-> out_strobe && out_result == '0)
    else $error("div_by_zero outside a zero result cycle");

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid |-> !busy)
    else $error("pipeline stalled the input side");
`endif

endmodule

// ===== src/fpa_div_pipe.sv =====
// Pipelined restoring divider (unsigned magnitudes), DIV_STEPS bits per stage.
// Carries a side_t sideband in step with the quotient. Depends on fpa_pkg.
module fpa_div_pipe import fpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [NUM_W-1:0]     in_num,
  input  logic [WORD_BITS-1:0] in_den,
  output logic                 out_valid,
  output side_t                out_side,
  output logic [NUM_W-1:0]     out_quo
);

  logic                 valid_r [DIV_STAGES];
  side_t                side_r  [DIV_STAGES];
  logic [NUM_W-1:0]     n_r     [DIV_STAGES];
  logic [WORD_BITS-1:0] rem_r   [DIV_STAGES];
  logic [WORD_BITS-1:0] den_r   [DIV_STAGES];

  logic                 valid_in [DIV_STAGES];
  side_t                side_in  [DIV_STAGES];
  logic [NUM_W-1:0]     n_in     [DIV_STAGES];
  logic [WORD_BITS-1:0] rem_in   [DIV_STAGES];
  logic [WORD_BITS-1:0] den_in   [DIV_STAGES];

  logic [NUM_W-1:0]     n_nxt    [DIV_STAGES];
  logic [WORD_BITS-1:0] rem_nxt  [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign valid_in[g] = in_valid;
      assign side_in[g]  = in_side;
      assign n_in[g]     = in_num;
      assign rem_in[g]   = '0;
      assign den_in[g]   = in_den;
    end else begin : g_next
      assign valid_in[g] = valid_r[g-1];
      assign side_in[g]  = side_r[g-1];
      assign n_in[g]     = n_r[g-1];
      assign rem_in[g]   = rem_r[g-1];
      assign den_in[g]   = den_r[g-1];
    end

    // numerator bits shift out the top, quotient bits shift in the bottom
    always_comb begin
      logic [NUM_W-1:0]     n_cur;
      logic [WORD_BITS-1:0] rem_cur;
      logic [WORD_BITS:0]   trial;
      logic [WORD_BITS:0]   diff;
      n_cur   = n_in[g];
      rem_cur = rem_in[g];
      trial   = '0;
      diff    = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (g * DIV_STEPS + k < NUM_W) begin
          trial = {rem_cur, n_cur[NUM_W-1]};
          diff  = trial - {1'b0, den_in[g]};
          if (trial >= {1'b0, den_in[g]}) begin
            rem_cur = diff[WORD_BITS-1:0];
            n_cur   = {n_cur[NUM_W-2:0], 1'b1};
          end else begin
            rem_cur = trial[WORD_BITS-1:0];
            n_cur   = {n_cur[NUM_W-2:0], 1'b0};
          end
        end
      end
      n_nxt[g]   = n_cur;
      rem_nxt[g] = rem_cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else begin
        valid_r[g] <= valid_in[g];
      end
    end

    always_ff @(posedge clk) begin
      side_r[g] <= side_in[g];
      n_r[g]    <= n_nxt[g];
      rem_r[g]  <= rem_nxt[g];
      den_r[g]  <= den_in[g];
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];
  assign out_quo   = n_r[DIV_STAGES-1];

endmodule
